/* sv/signed_restoring_divider_assert.svh */
// Assertion macros for the signed restoring divider.
`ifndef SIGNED_RESTORING_DIVIDER_ASSERT_SVH
`define SIGNED_RESTORING_DIVIDER_ASSERT_SVH

`ifndef SYNTH
`define SRD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("signed_restoring_divider: check failed");
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signed_restoring_divider: check failed");
`else
`define SRD_ASSERT(label, prop)
`define SRD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/srd_pkg.sv */
package srd_pkg;

    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

endpackage

/* sv/signed_restoring_divider.sv */
// Channel    Signals                     Request taken when
// ---------  --------------------------  ---------------------------------
// request    start, dividend, divisor    rising edge with start && !busy
// result     done, quotient, status      rising edge ending the done cycle
//
// One request per cycle; busy never rises, the pipeline has no stall source.
// The pipeline has an operand stage, one restoring subtract stage per
// quotient bit, and a sign/status output stage.
// rst_n clears the valid bits only; data in flight is dropped.
// The receiver cannot hold off results: each sits one cycle under done.
`include "signed_restoring_divider_assert.svh"

module signed_restoring_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                        done,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output srd_pkg::status_t            status
);
    import srd_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int LAT = DATA_WIDTH + 2;

    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ALL_ONE = {W{1'b1}};

    // stage k holds the state after k quotient bits
    logic          vld_reg [0:W];
    logic [W-1:0]  rem_reg [0:W];
    logic [W-1:0]  nq_reg  [0:W];
    logic [W-1:0]  den_reg [0:W];
    logic          neg_reg [0:W];
    status_t       st_reg  [0:W];

    logic          done_reg;
    logic [W-1:0]  quo_reg;
    status_t       status_reg;

    logic          accept;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    status_t       st_in;
    logic [W-1:0]  quo_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        mag_a = dividend[W-1] ? (~dividend + 1'b1) : dividend;
        mag_b = divisor[W-1]  ? (~divisor  + 1'b1) : divisor;
        priority if (divisor == '0)
            st_in = ST_DIV_ZERO;
        else if (dividend == MIN_VAL && divisor == ALL_ONE)
            st_in = ST_OVERFLOW;
        else
            st_in = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= mag_a;
            den_reg[0] <= mag_b;
            neg_reg[0] <= dividend[W-1] ^ divisor[W-1];
            st_reg[0]  <= st_in;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [W:0]   shifted;
        logic [W:0]   diff;
        logic         fits;
        logic [W-1:0] rem_next;
        logic [W-1:0] nq_next;

        always_comb
        begin
            shifted  = {rem_reg[k], nq_reg[k][W-1]};
            diff     = shifted - {1'b0, den_reg[k]};
            fits     = !diff[W];
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            nq_next  = {nq_reg[k][W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (vld_reg[k])
            begin
                rem_reg[k+1] <= rem_next;
                nq_reg[k+1]  <= nq_next;
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                st_reg[k+1]  <= st_reg[k];
            end
        end
    end

    always_comb
    begin
        unique case (st_reg[W])
            ST_DIV_ZERO: quo_next = ALL_ONE;
            ST_OVERFLOW: quo_next = MIN_VAL;
            default:     quo_next = neg_reg[W] ? (~nq_reg[W] + 1'b1) : nq_reg[W];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[W])
        begin
            quo_reg    <= quo_next;
            status_reg <= st_reg[W];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign status   = status_reg;

    `SRD_ASSERT_NEXT(a_enter, accept, vld_reg[0])
    `SRD_ASSERT(a_latency, done |-> $past(accept, LAT))
    `SRD_ASSERT(a_div_zero, (done && status == ST_DIV_ZERO) |-> (quotient == ALL_ONE))
    `SRD_ASSERT(a_overflow, (done && status == ST_OVERFLOW) |-> (quotient == MIN_VAL))
    `SRD_ASSERT(a_sign, (done && status == ST_OK && quotient != '0) |->
        (quotient[W-1] == $past(dividend[W-1] ^ divisor[W-1], LAT)))

endmodule

/* tb/signed_restoring_divider_checker.sv */
module signed_restoring_divider_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic                  done,
    input  logic [DATA_WIDTH-1:0] quotient,
    input  srd_pkg::status_t      status,
    output int                    failures,
    output int                    pending
);
    import srd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        status_t               status;
    } quotient_t;

    quotient_t expected_quotients[$];

    function automatic quotient_t divide_signed(logic [DATA_WIDTH-1:0] num,
                                                logic [DATA_WIDTH-1:0] den);
        quotient_t             res;
        logic [DATA_WIDTH-1:0] mag_num;
        logic [DATA_WIDTH-1:0] mag_den;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH:0]   rem;
        if (den == '0) begin
            res.quotient = ALL_ONES;
            res.status   = ST_DIV_ZERO;
        end
        else if (num == MOST_NEG && den == ALL_ONES) begin
            res.quotient = MOST_NEG;
            res.status   = ST_OVERFLOW;
        end
        else begin
            // magnitudes stay unsigned, so the most negative value is exact
            mag_num = num[DATA_WIDTH-1] ? -num : num;
            mag_den = den[DATA_WIDTH-1] ? -den : den;
            rem = '0;
            quo = '0;
            for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
                rem = {rem[DATA_WIDTH-1:0], mag_num[i]};
                quo = quo << 1;
                if (rem >= {1'b0, mag_den}) begin
                    rem    = rem - {1'b0, mag_den};
                    quo[0] = 1'b1;
                end
            end
            res.quotient = (num[DATA_WIDTH-1] != den[DATA_WIDTH-1]) ? -quo : quo;
            res.status   = ST_OK;
        end
        return res;
    endfunction

    always @(posedge clk) begin
        quotient_t want;
        if (!rst_n) begin
            failures = 0;
            pending  = 0;
            expected_quotients.delete();
        end
        else begin
            if (start && !busy)
                expected_quotients.push_back(divide_signed(dividend, divisor));
            if (done) begin
                if (expected_quotients.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got quotient %0d status %0d",
                             $time, $signed(quotient), status);
                    failures++;
                end
                else begin
                    want = expected_quotients.pop_front();
                    if (quotient !== want.quotient) begin
                        $display("%0t: quotient mismatch, expected %0d, got %0d",
                                 $time, $signed(want.quotient), $signed(quotient));
                        failures++;
                    end
                    if (status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, status);
                        failures++;
                    end
                end
            end
            pending = expected_quotients.size();
        end
    end

endmodule

/* tb/signed_restoring_divider_tb.sv */
module signed_restoring_divider_tb;
    import srd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int LATENCY = W + 2;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
    localparam logic [W-1:0] ZERO = '0;
    localparam logic [W-1:0] ONE = 1;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         done;
    logic [W-1:0] quotient;
    status_t      status;
    int           failures;
    int           pending;
    bit           no_idle;

    signed_restoring_divider #(
        .DATA_WIDTH(W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient),
        .status   (status)
    );

    signed_restoring_divider_checker #(
        .DATA_WIDTH(W)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient),
        .status   (status),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // entered and left at a falling edge; start stays high across back-to-back requests
    task automatic send_request(logic [W-1:0] num, logic [W-1:0] den);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [W-1:0] pick_operand();
        logic [W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 600) - 300;
            6:
            begin
                case ($urandom_range(0, 4))
                    0: v = ZERO;
                    1: v = ONE;
                    2: v = MINUS_ONE;
                    3: v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            7:
            begin
                v = ONE << $urandom_range(0, W - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:
            begin
                // spread of magnitudes so quotients of every length show up
                v = $urandom >> $urandom_range(0, W - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        dividend = '0;
        divisor  = '0;
        no_idle  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // divide by zero, overflow, most negative operands, sign combinations
        send_request(ZERO, ZERO);
        send_request(MOST_NEG, MINUS_ONE);
        send_request(MOST_NEG, ONE);
        send_request(MOST_NEG, MOST_NEG);
        send_request(MOST_POS, MOST_POS);
        send_request(MOST_POS, MINUS_ONE);
        send_request(MOST_POS, ONE);
        send_request(MINUS_ONE, MINUS_ONE);
        send_request(MINUS_ONE, ZERO);
        send_request(MOST_NEG, ZERO);
        send_request(MOST_POS, ZERO);
        send_request(ZERO, 5);
        send_request(7, 2);
        send_request(-7, 2);
        send_request(7, -2);
        send_request(-7, -2);
        send_request(MOST_NEG, 2);
        send_request(MOST_NEG, -2);
        send_request(MOST_POS, MOST_NEG);
        send_request(ONE, MOST_POS);
        send_request(MINUS_ONE, MOST_NEG);
        send_request(5, 7);
        drain_results();
        @(negedge clk);

        for (int n = 0; n < 1800; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n == 900)
                drain_results();
            send_request(pick_operand(), pick_operand());
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
